// ===== sv/gkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_pkg
// Shared constants and payload types of the group-of-k reverser.
// ----------------------------------------------------------------------------
package gkr_pkg;

    // buffer depth and word size
    localparam int MAX_GROUP  = 64;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int CFG_W      = 7;

    // input transaction
    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] word;
        logic                         final_word;
    } t_in;

    // output transaction
    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] out_word;
        logic                         run_last;
        logic                         sequence_end;
    } t_out;

    // one buffer read issued by the sequencer
    typedef struct packed {
        logic valid;
        logic last;
        logic seq_end;
    } t_rd_ctl;

    // group size clamped to 1..MAX_GROUP
    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] k;
        if (cfg == '0) begin
            k = CNT_W'(1);
        end else if (32'(cfg) > MAX_GROUP) begin
            k = CNT_W'(MAX_GROUP);
        end else begin
            k = CNT_W'(cfg);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/gkr_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_mem
// Group buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gkr_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [gkr_pkg::ADDR_W-1:0]    i_wr_addr,
    input  wire logic [gkr_pkg::WORD_WIDTH-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [gkr_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic      [gkr_pkg::WORD_WIDTH-1:0] o_rd_data
);
    import gkr_pkg::*;

    logic [WORD_WIDTH-1:0] r_mem [MAX_GROUP];
    logic [WORD_WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== sv/gkr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_seq
// Fill count, input handshake and read sequencing of a finished group.
// ----------------------------------------------------------------------------
module gkr_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_final,
    input  wire logic [gkr_pkg::CFG_W-1:0]      i_group_size,
    input  wire logic                           i_can_issue,
    output logic                                o_wr_en,
    output logic      [gkr_pkg::ADDR_W-1:0]     o_wr_addr,
    output logic      [gkr_pkg::ADDR_W-1:0]     o_rd_addr,
    output gkr_pkg::t_rd_ctl                    o_rd_ctl
);
    import gkr_pkg::*;

    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rev;
    logic              r_fin;

    logic [CNT_W-1:0]  n_fill;
    logic              in_acc;
    logic              full;
    logic              emit;
    logic              issue;
    logic              last;

    // input is stalled while a group is being read out; this also keeps
    // writes and reads of the buffer from overlapping
    assign o_in_stall = (r_cnt != '0);
    assign in_acc     = i_in_valid && (r_cnt == '0);
    assign n_fill     = r_fill + CNT_W'(1);
    assign full       = (n_fill >= eff_size(i_group_size));
    assign emit       = full || i_final;

    // buffer write of the accepted word
    assign o_wr_en   = in_acc;
    assign o_wr_addr = r_fill[ADDR_W-1:0];

    // read issue
    assign issue          = (r_cnt != '0) && i_can_issue;
    assign last           = (r_cnt == CNT_W'(1));
    assign o_rd_addr      = r_addr;
    assign o_rd_ctl.valid   = issue;
    assign o_rd_ctl.last    = last;
    assign o_rd_ctl.seq_end = last && r_fin;

    // fill count and readout counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
            r_addr <= '0;
            r_rev  <= 1'b0;
            r_fin  <= 1'b0;
        end else if (in_acc) begin
            if (emit) begin
                r_fill <= '0;
                r_cnt  <= n_fill;
                r_rev  <= full;
                r_fin  <= i_final;
                r_addr <= full ? r_fill[ADDR_W-1:0] : '0;
            end else begin
                r_fill <= n_fill;
            end
        end else if (issue) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_addr <= r_rev ? (r_addr - ADDR_W'(1)) : (r_addr + ADDR_W'(1));
        end
    end

endmodule
`default_nettype wire

// ===== sv/gkr_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_out
// Read-data stage and output register with flow control back to the reads.
// ----------------------------------------------------------------------------
module gkr_out (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gkr_pkg::t_rd_ctl               i_rd_ctl,
    input  wire logic [gkr_pkg::WORD_WIDTH-1:0] i_rd_data,
    output logic                                o_can_issue,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output gkr_pkg::t_out                       o_out_data
);
    import gkr_pkg::*;

    logic r_rd_valid;
    logic r_rd_last;
    logic r_rd_end;
    logic r_out_valid;
    t_out r_out;
    logic move;

    // read stage advances when the output register is free or being taken
    assign move        = !r_out_valid || !i_out_stall;
    assign o_can_issue = !r_rd_valid || move;

    // read stage flags, aligned with the memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_ctl.valid) begin
            r_rd_valid <= 1'b1;
        end else if (move) begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_ctl.valid) begin
            r_rd_last <= i_rd_ctl.last;
            r_rd_end  <= i_rd_ctl.seq_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && r_rd_valid) begin
            r_out.out_word     <= i_rd_data;
            r_out.run_last     <= r_rd_last;
            r_out.sequence_end <= r_rd_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== sv/group_of_k_reverser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// group_of_k_reverser_top
// Collects words into groups of the configured size and emits each full
// group reversed; a partial group at sequence end is emitted in order.
// ----------------------------------------------------------------------------
// An input transaction that does not close a group is accepted and gives
// no output. One that closes a group of n words (full, or ended by
// final_word) is accepted and then holds the input stalled while the
// group buffer's single read port delivers the n words, one word per
// cycle while the output does not stall. Output stall backs up into
// the reads. group_size is clamped to 1..64 (0 acts as 1) and must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module group_of_k_reverser_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [gkr_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire gkr_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output gkr_pkg::t_out                  o_out_data
);
    import gkr_pkg::*;

    logic [CFG_W-1:0]      r_group_size;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [WORD_WIDTH-1:0] rd_data;
    logic                  can_issue;
    t_rd_ctl               rd_ctl;

    // group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_group_size <= i_cfg_wr_data;
        end
    end

    gkr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_final      (i_in_data.final_word),
        .i_group_size (r_group_size),
        .i_can_issue  (can_issue),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_rd_ctl     (rd_ctl)
    );

    gkr_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.word),
        .i_rd_en   (rd_ctl.valid),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gkr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_ctl    (rd_ctl),
        .i_rd_data   (rd_data),
        .o_can_issue (can_issue),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== sv/gkr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_port_checks
// Port-level checks of the group-of-k reverser, bound to the top level.
// ----------------------------------------------------------------------------
module gkr_port_checks (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      o_in_stall,
    input  wire gkr_pkg::t_in              i_in_data,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    input  wire gkr_pkg::t_out             o_out_data
);
    import gkr_pkg::*;

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    // a final word always starts a readout
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.final_word |=> o_in_stall)
        else $error("final word did not start a readout");

    // sequence end only on the last word of a run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sequence_end |-> o_out_data.run_last)
        else $error("sequence end without run last");

endmodule

bind group_of_k_reverser_top gkr_port_checks u_gkr_port_checks (.*);
`default_nettype wire

// ===== tb/gkr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkr_checker
// Watches the input, output and group size ports of the group-of-k reverser.
// It keeps its own copy of the open group, works out the words that each
// accepted input transaction should release, and compares every accepted
// output transaction with the oldest of them, field by field.
// ----------------------------------------------------------------------------
module gkr_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [gkr_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  gkr_pkg::t_in                   i_in_data,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  gkr_pkg::t_out                  i_out_data,
    output int                             o_err_count,
    output int                             o_pending
);
    import gkr_pkg::*;

    // predicted state of the block
    logic [WORD_WIDTH-1:0] held_words [MAX_GROUP];
    int                    held_count;
    logic [CFG_W-1:0]      group_size_reg;

    // words still owed by the block, oldest first
    t_out                  reordered_words [$];

    initial begin
        o_err_count    = 0;
        o_pending      = 0;
        held_count     = 0;
        group_size_reg = CFG_W'(1);
    end

    // size in force: zero acts as one, large values saturate to the depth
    function automatic int clamp_group_size(input logic [CFG_W-1:0] cfg);
        int k;
        k = int'(cfg);
        if (k == 0) begin
            k = 1;
        end else if (k > MAX_GROUP) begin
            k = MAX_GROUP;
        end
        return k;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_err_count++;
    endtask

    // add one word to the open group and release the group when it closes
    task automatic collect_word(input t_in item);
        int   k;
        int   n;
        int   i;
        t_out r;
        k = clamp_group_size(group_size_reg);
        if (held_count < MAX_GROUP) begin
            held_words[held_count] = item.word;
            held_count++;
        end
        n = held_count;
        if (n >= k) begin
            // full group goes out newest first
            for (i = 0; i < n; i++) begin
                r.out_word     = held_words[n - 1 - i];
                r.run_last     = (i == n - 1);
                r.sequence_end = (i == n - 1) && item.final_word;
                reordered_words.push_back(r);
            end
            held_count = 0;
        end else if (item.final_word) begin
            // partial group at sequence end keeps arrival order
            for (i = 0; i < n; i++) begin
                r.out_word     = held_words[i];
                r.run_last     = (i == n - 1);
                r.sequence_end = (i == n - 1);
                reordered_words.push_back(r);
            end
            held_count = 0;
        end
    endtask

    task automatic check_output(input t_out got);
        t_out want;
        if (reordered_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected transaction, word %0d", got.out_word));
        end else begin
            want = reordered_words.pop_front();
            if (got.out_word !== want.out_word)
                flag_mismatch($sformatf("out_word %0d, expected %0d",
                                        got.out_word, want.out_word));
            if (got.run_last !== want.run_last)
                flag_mismatch($sformatf("run_last %b, expected %b",
                                        got.run_last, want.run_last));
            if (got.sequence_end !== want.sequence_end)
                flag_mismatch($sformatf("sequence_end %b, expected %b",
                                        got.sequence_end, want.sequence_end));
        end
    endtask

    // sample the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count     = 0;
            group_size_reg = CFG_W'(1);
            reordered_words.delete();
        end else begin
            if (i_cfg_wr_en)
                group_size_reg = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall)
                check_output(i_out_data);
            if (i_in_valid && !i_in_stall)
                collect_word(i_in_data);
        end
        o_pending = reordered_words.size();
    end

endmodule

// ===== tb/tb_group_of_k_reverser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_of_k_reverser_top
// Drives word sequences into the group-of-k reverser under changing group
// sizes and random idling on both channels; a checker beside the block
// predicts the reordered output and counts mismatches.
// ----------------------------------------------------------------------------
module tb_group_of_k_reverser_top;
    import gkr_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 380;
    localparam int SETTLE_CYCLES  = MAX_GROUP + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out             o_out_data;

    int               err_count;
    int               pending;
    int               send_gap_pct;
    int               out_stall_pct;
    int               idle_cycles;

    group_of_k_reverser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    gkr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // receiver stall, redrawn every falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_stall = 1'b0;
        else
            i_out_stall = ($urandom_range(0, 99) < out_stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // idling profile: 0 sender light / receiver heavy, 1 swapped, 2 none
    task automatic set_idle_profile(input int profile);
        case (profile)
            0: begin
                send_gap_pct  = 16;
                out_stall_pct = 74;
            end
            1: begin
                send_gap_pct  = 74;
                out_stall_pct = 16;
            end
            default: begin
                send_gap_pct  = 0;
                out_stall_pct = 0;
            end
        endcase
    endtask

    // one input transaction; valid stays high after acceptance
    task automatic send_word(input logic [WORD_WIDTH-1:0] w, input logic fin);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid           = 1'b1;
        i_in_data.word       = w;
        i_in_data.final_word = fin;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and let every owed word come out, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_group_size(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // random word, extremes now and then
    function automatic logic [WORD_WIDTH-1:0] pick_word();
        logic [WORD_WIDTH-1:0] w;
        case ($urandom_range(0, 31))
            0:       w = {1'b0, {(WORD_WIDTH-1){1'b1}}};
            1:       w = {1'b1, {(WORD_WIDTH-1){1'b0}}};
            2:       w = '0;
            3:       w = '1;
            default: w = WORD_WIDTH'($urandom);
        endcase
        return w;
    endfunction

    // mostly small sizes, sometimes zero, mid-range or saturating
    function automatic logic [CFG_W-1:0] pick_group_size();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = '0;
            1:       v = CFG_W'(MAX_GROUP);
            2:       v = CFG_W'($urandom_range(MAX_GROUP + 1, 127));
            3, 4:    v = CFG_W'($urandom_range(9, MAX_GROUP - 1));
            default: v = CFG_W'($urandom_range(1, 8));
        endcase
        return v;
    endfunction

    // stimulus
    initial begin
        int               rand_sent;
        int               seg_len;
        int               seq_left;
        int               k_eff;
        logic [CFG_W-1:0] size_v;
        logic             fin;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        idle_cycles   = 0;
        rand_sent     = 0;
        set_idle_profile(0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size passes words straight through, extremes of the word
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);

        // full group reversed, then a partial group in order
        set_group_size(CFG_W'(3));
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0006, 1'b1);

        // final word that completes a full group
        send_word(32'h0000_0007, 1'b0);
        send_word(32'h0000_0008, 1'b0);
        send_word(32'h0000_0009, 1'b1);

        // size zero acts as one
        set_group_size('0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);

        // size lowered while a group is open
        set_group_size(CFG_W'(4));
        send_word(32'h0000_0011, 1'b0);
        send_word(32'h0000_0012, 1'b0);
        send_word(32'h0000_0013, 1'b0);
        set_group_size(CFG_W'(2));
        send_word(32'h0000_0014, 1'b0);

        // size above the depth saturates, short sequence ends early
        set_group_size(CFG_W'(127));
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h8765_4321, 1'b1);

        // random segments, each under one group size
        while (rand_sent < RANDOM_ITEMS) begin
            size_v = pick_group_size();
            set_group_size(size_v);
            set_idle_profile(rand_sent * 3 / RANDOM_ITEMS);
            k_eff = (size_v == 0) ? 1 : ((int'(size_v) > MAX_GROUP) ? MAX_GROUP : int'(size_v));
            seg_len = (k_eff > 8) ? k_eff + $urandom_range(0, k_eff / 2)
                                  : $urandom_range(10, 30);
            if (seg_len > RANDOM_ITEMS - rand_sent)
                seg_len = RANDOM_ITEMS - rand_sent;
            seq_left = 0;
            repeat (seg_len) begin
                if (seq_left == 0)
                    seq_left = $urandom_range(1, 3 * k_eff);
                fin = (seq_left == 1) || ($urandom_range(0, 19) == 0);
                seq_left = fin ? 0 : seq_left - 1;
                send_word(pick_word(), fin);
                rand_sent++;
                // occasional full hold-off until the block has caught up
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
